>>> design/pic_pkg.sv
// shared types and constants for the priority interrupt controller
// no dependencies
`default_nettype none

package pic_pkg;

  // number of interrupt lines, line 0 is the most urgent
  localparam int NumLines = 8;
  localparam int IdxW     = (NumLines > 1) ? $clog2(NumLines) : 1;

  // fixed field widths of the transaction ports
  localparam int OpW   = 2;
  localparam int LineW = 3;
  localparam int VecW  = 3;
  localparam int BitsW = 8;

  typedef logic [NumLines-1:0] line_vec_t;
  typedef logic [IdxW-1:0]     line_idx_t;

  typedef enum logic [OpW-1:0] {
    OpRaise    = 2'd0,
    OpWithdraw = 2'd1,
    OpAck      = 2'd2,
    OpEoi      = 2'd3
  } op_e;

  // outcome of a lowest-set-bit search
  typedef struct packed {
    logic      found;
    line_idx_t idx;
  } first_t;

endpackage

`default_nettype wire

>>> design/priority_interrupt_controller.sv
// eight-line priority interrupt controller: request, in-service and pending state
// depends on pic_pkg for widths, opcodes and the search result type
`default_nettype none

// One transaction per cycle in unless the input is stalled, one result per
// transaction out. Each accepted transaction (raise, withdraw, acknowledge
// or specific end of interrupt) is applied to the request register, the
// in-service register and the pending flag in the cycle it is accepted, and
// its result (grant, vector and the register contents after the operation)
// appears in the output register on the next cycle.
// Line 0 is the most urgent. An acknowledge grants the most urgent requested
// line only when nothing is in service or that line beats every line in
// service; a refused or empty acknowledge changes nothing and reports
// granted = 0, vector = 0. The input is stalled only while a result sits in
// the output register and the consumer stalls it.
module priority_interrupt_controller (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // request channel
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [pic_pkg::OpW-1:0]  opcode_i,
  input  wire logic [pic_pkg::LineW-1:0] line_i,
  // result channel
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          granted_o,
  output logic [pic_pkg::VecW-1:0]      vector_o,
  output logic                          irq_pending_o,
  output logic [pic_pkg::BitsW-1:0]     request_bits_o,
  output logic [pic_pkg::BitsW-1:0]     service_bits_o
);

  // lowest set bit, i.e. most urgent line
  function automatic pic_pkg::first_t find_first(input pic_pkg::line_vec_t bits);
    pic_pkg::first_t res;
    res.found = 1'b0;
    res.idx   = '0;
    for (int i = pic_pkg::NumLines - 1; i >= 0; i--) begin
      if (bits[i]) begin
        res.found = 1'b1;
        res.idx   = pic_pkg::IdxW'(i);
      end
    end
    return res;
  endfunction

  // architectural state
  pic_pkg::line_vec_t request_q, request_d;
  pic_pkg::line_vec_t service_q, service_d;
  logic               pending_q, pending_d;

  // result register
  logic                      out_valid_q;
  logic                      granted_q, granted_d;
  logic [pic_pkg::VecW-1:0]  vector_q, vector_d;

  logic               accept;
  logic               in_range;
  pic_pkg::line_vec_t line_bit;
  pic_pkg::line_vec_t grant_bit;
  pic_pkg::first_t    req_first;
  pic_pkg::first_t    srv_first;
  logic               grant_ok;
  pic_pkg::op_e       op;

  // output register frees up when it is empty or being taken this cycle
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign op        = pic_pkg::op_e'(opcode_i);
  assign in_range  = 32'(line_i) < pic_pkg::NumLines;
  assign line_bit  = in_range ? (pic_pkg::line_vec_t'(1) << line_i) : '0;
  assign req_first = find_first(request_q);
  assign srv_first = find_first(service_q);

  // strict priority: the requested line must beat every line in service
  assign grant_ok  = req_first.found && (!srv_first.found || (req_first.idx < srv_first.idx));
  assign grant_bit = pic_pkg::line_vec_t'(1) << req_first.idx;

  always_comb begin
    request_d = request_q;
    service_d = service_q;
    pending_d = pending_q;
    granted_d = 1'b0;
    vector_d  = '0;
    case (op)
      pic_pkg::OpRaise: begin
        if (in_range) begin
          request_d = request_q | line_bit;
          pending_d = 1'b1;
        end
      end
      pic_pkg::OpWithdraw: begin
        // pending flag deliberately left alone
        request_d = request_q & ~line_bit;
      end
      pic_pkg::OpAck: begin
        if (grant_ok) begin
          request_d = request_q & ~grant_bit;
          service_d = service_q | grant_bit;
          if ((request_q & ~grant_bit) == '0) begin
            pending_d = 1'b0;
          end
          granted_d = 1'b1;
          vector_d  = pic_pkg::VecW'(req_first.idx);
        end
      end
      pic_pkg::OpEoi: begin
        service_d = service_q & ~line_bit;
      end
      default: begin
        request_d = request_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      request_q   <= '0;
      service_q   <= '0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        request_q   <= request_d;
        service_q   <= service_d;
        pending_q   <= pending_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      granted_q <= granted_d;
      vector_q  <= vector_d;
    end
  end

  // register contents after the step are the live state registers
  assign out_valid_o    = out_valid_q;
  assign granted_o      = granted_q;
  assign vector_o       = vector_q;
  assign irq_pending_o  = pending_q;
  assign request_bits_o = pic_pkg::BitsW'(request_q);
  assign service_bits_o = pic_pkg::BitsW'(service_q);

  // a granted line shows up in service in the same result
  a_grant_in_service: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && granted_o) |-> service_bits_o[vector_o])
    else $error("granted line not in service");

  // no grant reports vector zero
  a_no_grant_vector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !granted_o) |-> (vector_o == '0))
    else $error("vector nonzero without grant");

  // pending low means no request is outstanding
  a_pending_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pending_q |-> (request_q == '0))
    else $error("request held without pending flag");

  // every accepted transaction produces a result next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("result missing after transaction");

endmodule

`default_nettype wire
